// ----- sv/bsrp_pkg.sv -----
// Package: shared constants, types and state codes for the hypothesis stack.
package bsrp_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OCC_W = 6;
	localparam int BEAM_W = 24;
	localparam int LIM_W = 5;
	localparam int SC_W = 34;

	localparam logic CFG_BEAM_WIDTH = 1'b0;
	localparam logic CFG_STACK_LIMIT = 1'b1;

	localparam logic [1:0] ST_DISCARD = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_REPLACED = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	localparam logic KIND_REMOVED = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic [15:0] hypo_id;
		logic [31:0] recomb_key;
		logic signed [31:0] score;
	} in_t;

	typedef struct packed {
		logic kind;
		logic [15:0] entry_id;
		logic [1:0] status;
		logic [OCC_W-1:0] occupancy;
		logic last;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_CHKP, S_CAND, S_OUTER, S_INNER, S_JUDGE,
		S_REMOVE, S_EMIT, S_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic beam_chk;
		logic scan_clr;
		logic scan_step;
		logic apply;
		logic cand_step;
		logic outer_load;
		logic inner_step;
		logic judge;
		logic rem_step;
		logic rem_emit;
		logic fin_emit;
	} cmd_t;

	typedef struct packed {
		logic beam_ok;
		logic idx_last;
		logic oidx_last;
		logic inserted;
		logic need_prune;
		logic ncand_zero;
		logic is_thr;
		logic rem_hit;
		logic out_busy;
	} sts_t;

endpackage

// ----- sv/bsrp_if.sv -----
// Interfaces: valid/ready channel for hypotheses and results.
interface bsrp_in_if;
	logic valid;
	logic ready;
	bsrp_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bsrp_out_if;
	logic valid;
	logic ready;
	bsrp_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/bsrp_ctrl.sv -----
// Controller: sequences search, insertion, threshold selection and removal.
module bsrp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output bsrp_pkg::cmd_t cmd,
	input bsrp_pkg::sts_t sts
);
	import bsrp_pkg::*;

	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.beam_chk = 1'b1;
				if (!sts.beam_ok) nxt = S_FINAL;
				else begin
					cmd.scan_step = 1'b1;
					if (sts.idx_last) nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.apply = 1'b1;
				cmd.scan_clr = 1'b1;
				nxt = sts.inserted ? S_CHKP : S_FINAL;
			end
			S_CHKP: begin
				cmd.scan_clr = 1'b1;
				nxt = sts.need_prune ? S_CAND : S_FINAL;
			end
			S_CAND: begin
				cmd.cand_step = 1'b1;
				if (sts.idx_last) nxt = S_OUTER;
			end
			S_OUTER: begin
				if (sts.ncand_zero) nxt = S_FINAL;
				else begin
					cmd.outer_load = 1'b1;
					nxt = S_INNER;
				end
			end
			S_INNER: begin
				cmd.inner_step = 1'b1;
				if (sts.idx_last) nxt = S_JUDGE;
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				if (sts.is_thr) begin
					cmd.scan_clr = 1'b1;
					nxt = S_REMOVE;
				end else if (sts.oidx_last) nxt = S_FINAL;
				else nxt = S_OUTER;
			end
			S_REMOVE: begin
				if (sts.rem_hit) nxt = S_EMIT;
				else begin
					cmd.rem_step = 1'b1;
					if (sts.idx_last) nxt = S_FINAL;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.rem_emit = 1'b1;
					cmd.rem_step = 1'b1;
					nxt = sts.idx_last ? S_FINAL : S_REMOVE;
				end
			end
			S_FINAL: begin
				if (!sts.out_busy) begin
					cmd.fin_emit = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end
endmodule

// ----- sv/bsrp_dp.sv -----
// Datapath: slot table, best score, counters and the result register.
module bsrp_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [bsrp_pkg::BEAM_W-1:0] cfg_data,
	input bsrp_pkg::in_t in_data,
	input bsrp_pkg::cmd_t cmd,
	output bsrp_pkg::sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output bsrp_pkg::out_t out_data
);
	import bsrp_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [15:0] id_mem [TABLE_DEPTH];
	logic [31:0] key_mem [TABLE_DEPTH];
	logic signed [31:0] sc_mem [TABLE_DEPTH];

	logic signed [BEAM_W-1:0] beam_q;
	logic [LIM_W-1:0] limit_q;
	logic signed [31:0] best_q;
	logic [OCC_W-1:0] count_q;
	in_t hyp_q;
	logic [IDX_W-1:0] idx_q, oidx_q;
	logic found_q, free_q;
	logic [IDX_W-1:0] fidx_q, freeidx_q;
	logic [CNT_W-1:0] ncand_q, gt_q, ge_q;
	logic signed [31:0] thr_q;
	logic [1:0] fin_st_q;
	logic [OCC_W-1:0] occ_fin_q;

	logic signed [SC_W-1:0] floor_v, hyp_w;
	logic [LIM_W-1:0] lim;
	logic [CNT_W-1:0] k;
	logic cand_i, cand_o;
	logic signed [31:0] sc_i, sc_o;

	always_comb begin
		if (limit_q == '0) lim = LIM_W'(1);
		else if (32'(limit_q) > TABLE_DEPTH / 2) lim = LIM_W'(TABLE_DEPTH / 2);
		else lim = limit_q;
	end
	assign floor_v = SC_W'(best_q) + SC_W'(beam_q);
	assign hyp_w = SC_W'(hyp_q.score);
	assign k = (CNT_W'(lim) < ncand_q) ? CNT_W'(lim) : ncand_q;
	assign sc_i = sc_mem[idx_q];
	assign sc_o = sc_mem[oidx_q];
	assign cand_i = valid_q[idx_q] && (SC_W'(sc_i) > floor_v);
	assign cand_o = valid_q[oidx_q] && (SC_W'(sc_o) > floor_v);

	always_comb begin
		sts.beam_ok = !(hyp_w < floor_v);
		sts.idx_last = (32'(idx_q) == TABLE_DEPTH - 1);
		sts.oidx_last = (32'(oidx_q) == TABLE_DEPTH - 1);
		sts.inserted = found_q ? (hyp_q.score > sc_mem[fidx_q]) : free_q;
		sts.need_prune = (32'(count_q) >= 2 * 32'(lim)) && (32'(count_q) > 32'(lim));
		sts.ncand_zero = (ncand_q == '0);
		sts.is_thr = cand_o && (gt_q < k) && (ge_q >= k);
		sts.rem_hit = valid_q[idx_q] && (sc_i < thr_q);
		sts.out_busy = out_valid && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= BEAM_W'(-754513);
			limit_q <= LIM_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BEAM_WIDTH: beam_q <= cfg_data;
				CFG_STACK_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			best_q <= 32'sh8000_0000;
			count_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.rem_emit || cmd.fin_emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.load || cmd.scan_clr) idx_q <= '0;
			else if (cmd.scan_step || cmd.cand_step || cmd.inner_step || cmd.rem_step)
				idx_q <= idx_q + 1'b1;
			if (cmd.apply && sts.inserted) begin
				if (!found_q) begin
					valid_q[freeidx_q] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				if (hyp_q.score > best_q) best_q <= hyp_q.score;
			end
			if (cmd.rem_emit) begin
				valid_q[idx_q] <= 1'b0;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hyp_q <= in_data;
			found_q <= 1'b0;
			free_q <= 1'b0;
			ncand_q <= '0;
			oidx_q <= '0;
			fin_st_q <= ST_DISCARD;
		end
		if (cmd.scan_step) begin
			if (valid_q[idx_q]) begin
				if (!found_q && key_mem[idx_q] == hyp_q.recomb_key) begin
					found_q <= 1'b1;
					fidx_q <= idx_q;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
				freeidx_q <= idx_q;
			end
		end
		// settle the final status before the slot write changes the stored score
		if (cmd.apply) begin
			fin_st_q <= found_q ? (sts.inserted ? ST_REPLACED : ST_DROPPED) :
				(free_q ? ST_ADDED : ST_DISCARD);
		end
		if (cmd.apply && sts.inserted) begin
			if (found_q) begin
				id_mem[fidx_q] <= hyp_q.hypo_id;
				sc_mem[fidx_q] <= hyp_q.score;
			end else begin
				id_mem[freeidx_q] <= hyp_q.hypo_id;
				key_mem[freeidx_q] <= hyp_q.recomb_key;
				sc_mem[freeidx_q] <= hyp_q.score;
			end
		end
		if (cmd.cand_step && cand_i) ncand_q <= ncand_q + 1'b1;
		if (cmd.outer_load) begin
			gt_q <= '0;
			ge_q <= '0;
		end
		if (cmd.inner_step && cand_i) begin
			if (sc_i > sc_o) gt_q <= gt_q + 1'b1;
			if (sc_i >= sc_o) ge_q <= ge_q + 1'b1;
		end
		// every entry at or above the threshold is a candidate, so ge_q is what stays
		if (cmd.judge) begin
			if (sts.is_thr) begin
				thr_q <= sc_o;
				occ_fin_q <= OCC_W'(ge_q);
			end else if (!sts.oidx_last) oidx_q <= oidx_q + 1'b1;
		end
		if (cmd.rem_emit) begin
			out_data.kind <= KIND_REMOVED;
			out_data.entry_id <= id_mem[idx_q];
			out_data.status <= ST_DISCARD;
			out_data.occupancy <= occ_fin_q;
			out_data.last <= 1'b0;
		end
		if (cmd.fin_emit) begin
			out_data.kind <= KIND_FINAL;
			out_data.entry_id <= hyp_q.hypo_id;
			out_data.status <= fin_st_q;
			out_data.occupancy <= count_q;
			out_data.last <= 1'b1;
		end
	end
endmodule

// ----- sv/beam_stack_recombine_prune.sv -----
// Top level: beam-search hypothesis stack with recombination and lazy pruning.
//   channel | dir | payload                              | transaction
//   hyp     | in  | hypo_id, recomb_key, score           | valid && ready
//   res     | out | kind, entry_id, status, occupancy,last | valid && ready
//   cfg     | in  | cfg_we, cfg_index, cfg_data          | cfg_we high
// Sequence: without pruning one hypothesis goes from accept through a 32-slot key walk,
// decide, prune check and final result; a beam discard goes straight to the result.
// A prune adds candidate counting, a rank search for the threshold and a sweep that
// reports each removal. These steps share one index walk over the slot table.
// Reset clears valid bits, best score, occupancy and the state machine at once.
// A stalled result holds the controller; a new hypothesis is taken only when idle.
module beam_stack_recombine_prune (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [bsrp_pkg::BEAM_W-1:0] cfg_data,
	bsrp_in_if.sink hyp,
	bsrp_out_if.source res
);
	import bsrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Hold the sequencing in the controller; the tables, counters and result live in the datapath.
	bsrp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(hyp.valid), .in_ready(hyp.ready),
		.cmd(cmd), .sts(sts)
	);

	bsrp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_data(hyp.data), .cmd(cmd), .sts(sts),
		.out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
	);
endmodule

// ----- sv/bsrp_checker.sv -----
// Checker: port-level properties of the hypothesis stack, bound to the top level.
module bsrp_checker (
	input logic clk,
	input logic arst_n,
	input logic hyp_valid,
	input logic hyp_ready,
	input logic res_valid,
	input logic res_ready,
	input bsrp_pkg::out_t res_data
);
	import bsrp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped while stalled");
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.kind == res_data.last))
		else $error("last flag disagrees with kind");
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_data.occupancy) <= TABLE_DEPTH)
		else $error("occupancy beyond table depth");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hyp_valid && hyp_ready |=> !hyp_ready)
		else $error("second hypothesis taken while busy");
endmodule

bind beam_stack_recombine_prune bsrp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .hyp_valid(hyp.valid), .hyp_ready(hyp.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
